@@ rtl/weighted_clustering_coefficient_macros.svh @@
// Assertion macros shared by the weighted clustering coefficient RTL.
// No dependencies; the asserting files include it by name.
`ifndef WEIGHTED_CLUSTERING_COEFFICIENT_MACROS_SVH
`define WEIGHTED_CLUSTERING_COEFFICIENT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wcc assertion failed");
`define WCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wcc assertion failed");
`else
`define WCC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WCC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/wcc_pkg.sv @@
// Constants and types of the weighted clustering coefficient block.
// No dependencies.
`default_nettype none
package wcc_pkg;
   localparam int NODES       = 64;
   localparam int NODE_BITS   = $clog2(NODES);
   localparam int ADDR_BITS   = 2 * NODE_BITS;
   localparam int WEIGHT_BITS = 16;
   localparam int EDGE_BITS   = WEIGHT_BITS + 1;
   localparam int COEF_BITS   = 17;
   localparam int DEG_BITS    = 7;
   localparam int CFG_BITS    = 7;
   localparam int MODE_BITS   = 2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_WRITE = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_MEAN  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;
endpackage
`default_nettype wire

@@ rtl/wcc_channels.sv @@
// Handshake interfaces for the request and response channels.
// Depends on wcc_pkg.
`default_nettype none
interface wcc_req_if;
   logic                          valid;
   logic                          ready;
   logic [wcc_pkg::MODE_BITS-1:0]   mode;
   logic [wcc_pkg::NODE_BITS-1:0]   row;
   logic [wcc_pkg::NODE_BITS-1:0]   col;
   logic [wcc_pkg::WEIGHT_BITS-1:0] weight;
   modport source (output valid, mode, row, col, weight, input ready);
   modport sink (input valid, mode, row, col, weight, output ready);
endinterface

interface wcc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wcc_pkg::COEF_BITS-1:0] coefficient;
   logic [wcc_pkg::DEG_BITS-1:0]  degree;
   modport source (output valid, coefficient, degree, input ready);
   modport sink (input valid, coefficient, degree, output ready);
endinterface
`default_nettype wire

@@ rtl/weighted_clustering_coefficient.sv @@
// An edge write goes to the edge memory when accepted; a clear sweeps the whole memory.
// A query below degree 2 gives zero; else it walks each neighbor a, the columns after it,
// each neighbor pair and each pair whose closing edge exists, with a 33-step divider and a
// 17-step cube root. A mean runs the query for each node below the configured node count,
// then one more division; one item is in flight at a time. Reset is synchronous; after it
// the block sweeps the edge memory before it accepts a request.
`default_nettype none
`include "weighted_clustering_coefficient_macros.svh"
module weighted_clustering_coefficient (
   input  wire logic                         clock,
   input  wire logic                         reset,
   wcc_req_if.sink                           req_ch,
   wcc_rsp_if.source                         rsp_ch,
   input  wire logic                         csr_wr_en,
   input  wire logic [wcc_pkg::CFG_BITS-1:0] csr_wr_data
);
   localparam int NB = wcc_pkg::NODE_BITS;
   localparam int AB = wcc_pkg::ADDR_BITS;
   localparam int WB = wcc_pkg::WEIGHT_BITS;
   localparam int EB = wcc_pkg::EDGE_BITS;
   localparam int CB = wcc_pkg::COEF_BITS;
   localparam int DB = wcc_pkg::DEG_BITS;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_CNT_RD, S_CNT_USE, S_A_RD, S_A_USE, S_B_RD, S_B_USE,
      S_AB_RD, S_AB_USE, S_MUL1, S_MUL2, S_CBRT_A, S_CBRT_B, S_NEXT_B,
      S_NEXT_A, S_FINAL, S_DIV, S_NODE_DONE, S_OUT
   } state_type;

   typedef enum logic [2:0] {
      DST_KA, DST_KB, DST_AB, DST_COEF, DST_MEAN
   } dst_type;

   state_type         state_ff;
   dst_type           div_dst_ff;
   logic [AB-1:0]     clr_ff;
   logic [6:0]        node_count_ff;
   logic [WB-1:0]     largest_ff;
   logic [NB-1:0]     k_ff, c_ff, a_ff, b_ff;
   logic [DB-1:0]     d_ff, n_ff;
   logic              mean_ff;
   logic [27:0]       sum_ff;
   logic [22:0]       total_ff;
   logic [CB-1:0]     coef_ff, wka_ff, wkb_ff, wab_ff;
   logic [33:0]       prod_ff;
   logic [50:0]       x_ff;
   logic [16:0]       y_ff;
   logic [36:0]       bq_ff;
   logic [4:0]        cb_cnt_ff;
   logic [32:0]       div_num_ff;
   logic [15:0]       div_den_ff, div_rem_ff;
   logic [5:0]        div_cnt_ff;
   logic              rsp_valid_ff;
   logic [CB-1:0]     rsp_coef_ff;
   logic [DB-1:0]     rsp_deg_ff;
   logic [EB-1:0]     mem_q_ff;
   logic [EB-1:0]     edge_mem [wcc_pkg::NODES*wcc_pkg::NODES];

   logic              mem_we;
   logic [AB-1:0]     mem_wa, mem_ra;
   logic [EB-1:0]     mem_wd;
   logic              accept, present;
   logic [16:0]       div_sh, div_sub;
   logic              div_ge;
   logic [CB-1:0]     div_q;
   logic [5:0]        cb_sa;
   logic [50:0]       cb_shift, cb_bsh;
   logic              cb_ge;
   logic [16:0]       y2;
   logic [34:0]       ym;
   logic [36:0]       bq_in;
   logic [DB-1:0]     d_in, n_in;
   logic [13:0]       dd;
   logic [32:0]       norm_num;

   assign accept   = req_ch.valid && req_ch.ready;
   assign present  = mem_q_ff[WB];
   assign norm_num = {1'b0, mem_q_ff[WB-1:0], 16'd0};

   assign div_sh  = {div_rem_ff, div_num_ff[32]};
   assign div_ge  = div_sh >= {1'b0, div_den_ff};
   assign div_sub = div_sh - {1'b0, div_den_ff};
   assign div_q   = {div_num_ff[15:0], div_ge};

   assign cb_sa    = {cb_cnt_ff, 1'b0} + {1'b0, cb_cnt_ff};
   assign cb_shift = x_ff >> cb_sa;
   assign cb_ge    = cb_shift >= {14'd0, bq_ff};
   assign cb_bsh   = {14'd0, bq_ff} << cb_sa;
   assign y2       = {y_ff[15:0], 1'b0};
   assign ym       = y2 * ({1'b0, y2} + 18'd1);
   assign bq_in    = {1'b0, ym, 1'b0} + {2'b0, ym} + 37'd1;

   assign d_in = d_ff + {{(DB-1){1'b0}}, present};
   assign dd   = d_ff * (d_ff - 7'd1);
   assign n_in = (node_count_ff == 7'd0) ? 7'd1 :
                 (node_count_ff > 7'(wcc_pkg::NODES)) ? 7'(wcc_pkg::NODES) :
                 node_count_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff;
      mem_wd = '0;
      mem_ra = {k_ff, c_ff};
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_IDLE: begin
            mem_we = accept && (req_ch.mode == wcc_pkg::MODE_WRITE);
            mem_wa = {req_ch.row, req_ch.col};
            mem_wd = {1'b1, req_ch.weight};
         end
         S_A_RD:  mem_ra = {k_ff, a_ff};
         S_B_RD:  mem_ra = {k_ff, b_ff};
         S_AB_RD: mem_ra = {a_ff, b_ff};
         default: mem_ra = {k_ff, c_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         edge_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= edge_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         node_count_ff <= 7'd64;
         largest_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         mean_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == {AB{1'b1}}) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  d_ff <= '0;
                  c_ff <= '0;
                  case (req_ch.mode)
                     wcc_pkg::MODE_WRITE: begin
                        if (req_ch.weight > largest_ff) begin
                           largest_ff <= req_ch.weight;
                        end
                     end
                     wcc_pkg::MODE_QUERY: begin
                        k_ff     <= req_ch.row;
                        mean_ff  <= 1'b0;
                        state_ff <= S_CNT_RD;
                     end
                     wcc_pkg::MODE_MEAN: begin
                        k_ff     <= '0;
                        mean_ff  <= 1'b1;
                        n_ff     <= n_in;
                        total_ff <= '0;
                        state_ff <= S_CNT_RD;
                     end
                     default: begin
                        clr_ff     <= '0;
                        largest_ff <= '0;
                        state_ff   <= S_CLEAR;
                     end
                  endcase
               end
            end
            S_CNT_RD: state_ff <= S_CNT_USE;
            S_CNT_USE: begin
               d_ff <= d_in;
               c_ff <= c_ff + 1'b1;
               if (c_ff == {NB{1'b1}}) begin
                  if (d_in < 7'd2 || largest_ff == '0) begin
                     coef_ff  <= '0;
                     state_ff <= S_NODE_DONE;
                  end else begin
                     sum_ff   <= '0;
                     a_ff     <= '0;
                     state_ff <= S_A_RD;
                  end
               end else begin
                  state_ff <= S_CNT_RD;
               end
            end
            S_A_RD: state_ff <= S_A_USE;
            S_A_USE: begin
               if (present && a_ff != {NB{1'b1}}) begin
                  div_num_ff <= norm_num;
                  div_den_ff <= largest_ff;
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  div_dst_ff <= DST_KA;
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_NEXT_A;
               end
            end
            S_B_RD: state_ff <= S_B_USE;
            S_B_USE: begin
               if (present) begin
                  div_num_ff <= norm_num;
                  div_den_ff <= largest_ff;
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  div_dst_ff <= DST_KB;
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_NEXT_B;
               end
            end
            S_AB_RD: state_ff <= S_AB_USE;
            S_AB_USE: begin
               if (present && mem_q_ff[WB-1:0] != '0) begin
                  div_num_ff <= norm_num;
                  div_den_ff <= largest_ff;
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  div_dst_ff <= DST_AB;
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_NEXT_B;
               end
            end
            S_MUL1: begin
               prod_ff  <= wab_ff * wka_ff;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               x_ff      <= prod_ff * wkb_ff;
               y_ff      <= '0;
               cb_cnt_ff <= 5'd16;
               state_ff  <= S_CBRT_A;
            end
            S_CBRT_A: begin
               y_ff     <= y2;
               bq_ff    <= bq_in;
               state_ff <= S_CBRT_B;
            end
            S_CBRT_B: begin
               if (cb_ge) begin
                  x_ff <= x_ff - cb_bsh;
               end
               if (cb_cnt_ff == 5'd0) begin
                  sum_ff   <= sum_ff + {11'd0, y_ff + {16'd0, cb_ge}};
                  state_ff <= S_NEXT_B;
               end else begin
                  y_ff      <= y_ff + {16'd0, cb_ge};
                  cb_cnt_ff <= cb_cnt_ff - 1'b1;
                  state_ff  <= S_CBRT_A;
               end
            end
            S_NEXT_B: begin
               if (b_ff == {NB{1'b1}}) begin
                  state_ff <= S_NEXT_A;
               end else begin
                  b_ff     <= b_ff + 1'b1;
                  state_ff <= S_B_RD;
               end
            end
            S_NEXT_A: begin
               if (a_ff == {NB{1'b1}}) begin
                  state_ff <= S_FINAL;
               end else begin
                  a_ff     <= a_ff + 1'b1;
                  state_ff <= S_A_RD;
               end
            end
            S_FINAL: begin
               div_num_ff <= {4'd0, sum_ff, 1'b0};
               div_den_ff <= {2'd0, dd};
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               div_dst_ff <= DST_COEF;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               div_rem_ff <= div_ge ? div_sub[15:0] : div_sh[15:0];
               div_num_ff <= {div_num_ff[31:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 6'd32) begin
                  case (div_dst_ff)
                     DST_KA: begin
                        wka_ff   <= div_q;
                        b_ff     <= a_ff + 1'b1;
                        state_ff <= S_B_RD;
                     end
                     DST_KB: begin
                        wkb_ff   <= div_q;
                        state_ff <= S_AB_RD;
                     end
                     DST_AB: begin
                        wab_ff   <= div_q;
                        state_ff <= S_MUL1;
                     end
                     DST_COEF: begin
                        coef_ff  <= div_q;
                        state_ff <= S_NODE_DONE;
                     end
                     default: begin
                        coef_ff  <= div_q;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_NODE_DONE: begin
               if (mean_ff) begin
                  if ({1'b0, k_ff} == n_ff - 7'd1) begin
                     div_num_ff <= {10'd0, total_ff + {6'd0, coef_ff}};
                     div_den_ff <= {9'd0, n_ff};
                     div_rem_ff <= '0;
                     div_cnt_ff <= '0;
                     div_dst_ff <= DST_MEAN;
                     state_ff   <= S_DIV;
                  end else begin
                     total_ff <= total_ff + {6'd0, coef_ff};
                     k_ff     <= k_ff + 1'b1;
                     d_ff     <= '0;
                     c_ff     <= '0;
                     state_ff <= S_CNT_RD;
                  end
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_coef_ff  <= coef_ff;
                  rsp_deg_ff   <= mean_ff ? '0 : d_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.coefficient = rsp_coef_ff;
   assign rsp_ch.degree      = rsp_deg_ff;

   `WCC_ASSERT_IMP(a_coef_range, clock, reset, rsp_valid_ff, rsp_coef_ff <= 17'd65536)
   `WCC_ASSERT_IMP(a_div_count, clock, reset, state_ff == S_DIV, div_cnt_ff <= 6'd32)
   `WCC_ASSERT_NXT(a_clear_blocks, clock, reset, state_ff == S_CLEAR && clr_ff != {AB{1'b1}}, !req_ch.ready)
endmodule
`default_nettype wire
